FILE: rtl/lob_pkg.sv
// ----------------------------------------------------------------------------
// lob_pkg
// Shared types and constants of the limit order book matcher: slot sizing,
// result status codes, stored slot layout and controller/datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package lob_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int SLOT_W      = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CNT_W       = $clog2(ORDER_SLOTS + 2);
  localparam int REST_W      = 6;

  typedef logic [SLOT_W-1:0] slot_idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [2:0] {
    ST_FILL      = 3'd0,
    ST_ACCEPTED  = 3'd1,
    ST_BAD_QTY   = 3'd2,
    ST_BAD_PRICE = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_CANCELLED = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_BOOK_FULL = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    SCAN_ID    = 2'd0,
    SCAN_MATCH = 2'd1,
    SCAN_STAT  = 2'd2
  } scan_mode_t;

  localparam logic REQ_CANCEL  = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic KIND_MARKET = 1'b1;

  typedef struct packed {
    logic [31:0] ord_id;
    logic        side;
    logic [30:0] price;
    logic [30:0] quantity;
    logic [31:0] account;
    logic [31:0] arrival;
  } entry_t;

  typedef struct packed {
    logic       load_in;
    logic       scan_clr;
    logic       scan_rd;
    slot_idx_t  scan_addr;
    scan_mode_t scan_mode;
    logic       cancel_clr;
    logic       emit_fill;
    logic       rest;
    logic       emit_stat;
    logic       st_set;
    status_t    st_code;
  } cmd_t;

  typedef struct packed {
    logic in_cancel;
    logic in_bad_qty;
    logic in_bad_price;
    logic tk_cancel;
    logic tk_market;
    logic found;
    logic best_found;
    logic limit_stop;
    logic rem_done;
    logic free_found;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/lob_ram.sv
// ----------------------------------------------------------------------------
// lob_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lob_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/lob_ctrl.sv
// ----------------------------------------------------------------------------
// lob_ctrl
// Request sequencer: id scan, repeated best-maker scans with fills, resting
// of the remainder, and the final book status scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lob_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire lob_pkg::sts_t sts,
  output lob_pkg::cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FILL  = 5'b00100,
    S_AFTER = 5'b01000,
    S_STAT  = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  lob_pkg::cnt_t       cnt_r, cnt_nxt;
  lob_pkg::scan_mode_t mode_r, mode_nxt;
  logic                scan_end;

  // the scan runs on past the last slot read so that it settles in the scan registers
  assign scan_end = (cnt_r == lob_pkg::cnt_t'(lob_pkg::ORDER_SLOTS + 1));
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    cmd           = '0;
    cmd.scan_mode = mode_r;
    cmd.st_code   = lob_pkg::ST_ACCEPTED;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_SCAN;
          cnt_nxt     = '0;
          mode_nxt    = lob_pkg::SCAN_ID;
          if (!sts.in_cancel && sts.in_bad_qty) begin
            cmd.st_set  = 1'b1;
            cmd.st_code = lob_pkg::ST_BAD_QTY;
            mode_nxt    = lob_pkg::SCAN_STAT;
          end else if (!sts.in_cancel && sts.in_bad_price) begin
            cmd.st_set  = 1'b1;
            cmd.st_code = lob_pkg::ST_BAD_PRICE;
            mode_nxt    = lob_pkg::SCAN_STAT;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_clr  = (cnt_r == '0);
        cmd.scan_rd   = (cnt_r < lob_pkg::cnt_t'(lob_pkg::ORDER_SLOTS));
        cmd.scan_addr = cnt_r[lob_pkg::SLOT_W-1:0];
        if (!scan_end) begin
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cnt_nxt = '0;
          case (mode_r)
            lob_pkg::SCAN_ID: begin
              cmd.st_set = 1'b1;
              mode_nxt   = lob_pkg::SCAN_STAT;
              if (sts.tk_cancel) begin
                cmd.cancel_clr = sts.found;
                cmd.st_code    = sts.found ? lob_pkg::ST_CANCELLED : lob_pkg::ST_NOT_FOUND;
              end else if (sts.found) begin
                cmd.st_code = lob_pkg::ST_DUPLICATE;
              end else begin
                cmd.st_set = 1'b0;
                mode_nxt   = lob_pkg::SCAN_MATCH;
              end
            end
            lob_pkg::SCAN_MATCH: begin
              state_nxt = (sts.best_found && !sts.limit_stop) ? S_FILL : S_AFTER;
            end
            default: begin
              state_nxt = S_STAT;
            end
          endcase
        end
      end
      S_FILL: begin
        if (sts.out_free) begin
          cmd.emit_fill = 1'b1;
          state_nxt     = S_SCAN;
          cnt_nxt       = '0;
          if (sts.rem_done) begin
            cmd.st_set = 1'b1;
            cmd.st_code = lob_pkg::ST_ACCEPTED;
            mode_nxt   = lob_pkg::SCAN_STAT;
          end else begin
            mode_nxt = lob_pkg::SCAN_MATCH;
          end
        end
      end
      S_AFTER: begin
        // drop market remainder; rest limit remainder if a slot is free
        cmd.st_set = 1'b1;
        if (sts.tk_market) begin
          cmd.st_code = lob_pkg::ST_ACCEPTED;
        end else if (sts.free_found) begin
          cmd.rest    = 1'b1;
          cmd.st_code = lob_pkg::ST_ACCEPTED;
        end else begin
          cmd.st_code = lob_pkg::ST_BOOK_FULL;
        end
        state_nxt = S_SCAN;
        cnt_nxt   = '0;
        mode_nxt  = lob_pkg::SCAN_STAT;
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.emit_stat = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      mode_r  <= lob_pkg::SCAN_ID;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      mode_r  <= mode_nxt;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_fill || cmd.emit_stat) |-> sts.out_free)
    else $error("result emitted while output register busy");

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register not one-hot");

  a_stat_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_stat |=> (state_r == S_IDLE))
    else $error("status item did not end the request");

  a_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_rd |-> (state_r == S_SCAN))
    else $error("slot read outside a scan");

endmodule

`default_nettype wire

FILE: rtl/lob_dpath.sv
// ----------------------------------------------------------------------------
// lob_dpath
// Slot storage, scan evaluation (id match, best maker, book summary), fill
// arithmetic, remainder resting and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lob_dpath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_req_type,
  input  wire logic [31:0]   in_ord_id,
  input  wire logic          in_side,
  input  wire logic          in_order_kind,
  input  wire logic signed [31:0] in_price,
  input  wire logic signed [31:0] in_quantity,
  input  wire logic [31:0]   in_account,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [2:0]         out_status,
  output logic [31:0]        out_maker_id,
  output logic [31:0]        out_taker_id,
  output logic [30:0]        out_fill_price,
  output logic [30:0]        out_exec_qty,
  output logic [30:0]        out_top_bid,
  output logic               out_bid_valid,
  output logic [30:0]        out_top_ask,
  output logic               out_ask_valid,
  output logic [30:0]        out_spread_value,
  output logic [5:0]         out_resting_count,
  output logic               out_last,
  input  wire lob_pkg::cmd_t cmd,
  output lob_pkg::sts_t      sts
);

  // taker request
  logic        tk_cancel_r;
  logic [31:0] tk_id_r;
  logic        tk_side_r;
  logic        tk_kind_r;
  logic [30:0] tk_price_r;
  logic [31:0] tk_acct_r;
  logic [30:0] rem_r;
  logic [31:0] arr_r;
  lob_pkg::status_t st_r;

  logic [lob_pkg::ORDER_SLOTS-1:0] valid_r;

  // slot memory
  logic              ram_we;
  lob_pkg::slot_idx_t ram_waddr;
  lob_pkg::entry_t   ram_wdata, ram_rdata;

  lob_ram #(
    .WIDTH($bits(lob_pkg::entry_t)),
    .DEPTH(lob_pkg::ORDER_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(cmd.scan_addr),
    .rdata(ram_rdata)
  );

  // scan evaluation stage
  logic               ev_r;
  lob_pkg::slot_idx_t ev_idx_r;
  logic               found_r;
  lob_pkg::slot_idx_t found_idx_r;
  logic               best_found_r;
  lob_pkg::slot_idx_t best_idx_r;
  lob_pkg::entry_t    best_e_r;
  logic [31:0]        best_age_r;
  logic [30:0]        bid_r, ask_r;
  logic               hb_r, ha_r;
  logic [lob_pkg::REST_W-1:0] cnt_r;

  logic        ev_valid, elig, better, take;
  logic [31:0] age;
  logic [30:0] fq;
  logic        free_found;
  lob_pkg::slot_idx_t free_idx;

  assign ev_valid = valid_r[ev_idx_r];
  assign age      = arr_r - ram_rdata.arrival;
  assign elig     = ev_valid && (ram_rdata.side != tk_side_r) &&
                    !((tk_acct_r != '0) && (ram_rdata.account == tk_acct_r));
  assign better   = (tk_side_r == lob_pkg::SIDE_BUY) ? (ram_rdata.price < best_e_r.price)
                                                     : (ram_rdata.price > best_e_r.price);
  assign take     = !best_found_r ||
                    ((ram_rdata.price == best_e_r.price) ? (age > best_age_r) : better);

  assign fq = (rem_r < best_e_r.quantity) ? rem_r : best_e_r.quantity;

  always_comb begin
    free_idx = '0;
    for (int i = lob_pkg::ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = lob_pkg::slot_idx_t'(i);
      end
    end
  end
  assign free_found = ~&valid_r;

  always_comb begin
    ram_we    = cmd.emit_fill || cmd.rest;
    ram_waddr = cmd.rest ? free_idx : best_idx_r;
    ram_wdata = best_e_r;
    ram_wdata.quantity = best_e_r.quantity - fq;
    if (cmd.rest) begin
      ram_wdata.ord_id   = tk_id_r;
      ram_wdata.side     = tk_side_r;
      ram_wdata.price    = tk_price_r;
      ram_wdata.quantity = rem_r;
      ram_wdata.account  = tk_acct_r;
      ram_wdata.arrival  = arr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
    end else begin
      ev_r <= cmd.scan_rd;
    end
    ev_idx_r <= cmd.scan_addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      found_r      <= 1'b0;
      best_found_r <= 1'b0;
      hb_r         <= 1'b0;
      ha_r         <= 1'b0;
      bid_r        <= '0;
      ask_r        <= '0;
      cnt_r        <= '0;
    end else if (ev_r) begin
      case (cmd.scan_mode)
        lob_pkg::SCAN_ID: begin
          if (ev_valid && (ram_rdata.ord_id == tk_id_r) && !found_r) begin
            found_r     <= 1'b1;
            found_idx_r <= ev_idx_r;
          end
        end
        lob_pkg::SCAN_MATCH: begin
          if (elig && take) begin
            best_found_r <= 1'b1;
            best_idx_r   <= ev_idx_r;
            best_e_r     <= ram_rdata;
            best_age_r   <= age;
          end
        end
        lob_pkg::SCAN_STAT: begin
          if (ev_valid) begin
            cnt_r <= cnt_r + 1'b1;
            if (ram_rdata.side == lob_pkg::SIDE_BUY) begin
              if (!hb_r || (ram_rdata.price > bid_r)) bid_r <= ram_rdata.price;
              hb_r <= 1'b1;
            end else begin
              if (!ha_r || (ram_rdata.price < ask_r)) ask_r <= ram_rdata.price;
              ha_r <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // hold maker quantity copy in step with the memory write
    if (cmd.emit_fill) begin
      best_e_r.quantity <= best_e_r.quantity - fq;
    end
  end

  // taker and book registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      arr_r   <= '0;
    end else begin
      if (cmd.cancel_clr) valid_r[found_idx_r] <= 1'b0;
      if (cmd.emit_fill && (best_e_r.quantity == fq)) valid_r[best_idx_r] <= 1'b0;
      if (cmd.rest) begin
        valid_r[free_idx] <= 1'b1;
        arr_r             <= arr_r + 32'd1;
      end
    end
    if (cmd.load_in) begin
      tk_cancel_r <= in_req_type;
      tk_id_r     <= in_ord_id;
      tk_side_r   <= in_side;
      tk_kind_r   <= in_order_kind;
      tk_price_r  <= in_price[30:0];
      tk_acct_r   <= in_account;
      rem_r       <= in_quantity[30:0];
    end else if (cmd.emit_fill) begin
      rem_r <= rem_r - fq;
    end
    if (cmd.st_set) st_r <= cmd.st_code;
  end

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_fill || cmd.emit_stat) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit_fill) begin
      out_status        <= lob_pkg::ST_FILL;
      out_maker_id      <= best_e_r.ord_id;
      out_taker_id      <= tk_id_r;
      out_fill_price    <= best_e_r.price;
      out_exec_qty      <= fq;
      out_top_bid       <= '0;
      out_bid_valid     <= 1'b0;
      out_top_ask       <= '0;
      out_ask_valid     <= 1'b0;
      out_spread_value  <= '0;
      out_resting_count <= '0;
      out_last          <= 1'b0;
    end else if (cmd.emit_stat) begin
      out_status        <= st_r;
      out_maker_id      <= '0;
      out_taker_id      <= tk_id_r;
      out_fill_price    <= '0;
      out_exec_qty      <= '0;
      out_top_bid       <= bid_r;
      out_bid_valid     <= hb_r;
      out_top_ask       <= ask_r;
      out_ask_valid     <= ha_r;
      out_spread_value  <= (hb_r && ha_r && (ask_r > bid_r)) ? (ask_r - bid_r) : '0;
      out_resting_count <= cnt_r;
      out_last          <= 1'b1;
    end
  end
  assign out_valid = out_valid_r;

  always_comb begin
    sts.in_cancel    = (in_req_type == lob_pkg::REQ_CANCEL);
    sts.in_bad_qty   = in_quantity[31] || (in_quantity == '0);
    sts.in_bad_price = (in_order_kind != lob_pkg::KIND_MARKET) &&
                       (in_price[31] || (in_price == '0));
    sts.tk_cancel    = tk_cancel_r;
    sts.tk_market    = (tk_kind_r == lob_pkg::KIND_MARKET);
    sts.found        = found_r;
    sts.best_found   = best_found_r;
    sts.limit_stop   = (tk_kind_r != lob_pkg::KIND_MARKET) &&
                       ((tk_side_r == lob_pkg::SIDE_BUY) ? (best_e_r.price > tk_price_r)
                                                         : (best_e_r.price < tk_price_r));
    sts.rem_done     = (rem_r <= best_e_r.quantity);
    sts.free_found   = free_found;
    sts.out_free     = !out_valid_r || !out_stall;
  end

  a_fill_qty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_fill |-> (fq != '0))
    else $error("fill with zero quantity");

  a_rest_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rest |=> valid_r[$past(free_idx)])
    else $error("rested order slot not marked valid");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled result dropped");

endmodule

`default_nettype wire

FILE: rtl/limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book over ORDER_SLOTS slots held in one RAM.
// ----------------------------------------------------------------------------
// Every slot scan reads the RAM one slot per cycle. A rejected qty or price goes
// straight to the book status scan. Cancel or duplicate: id scan, then status
// scan. Add: id scan, match scans with fills, resting, then the status scan.
// One request is in work at a time; the next is taken in the cycle after its
// status item is registered. Reset (synchronous, active low) empties the book.
`default_nettype none

module limit_order_book_matcher (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_req_type,
  input  wire logic [31:0]        in_ord_id,
  input  wire logic               in_side,
  input  wire logic               in_order_kind,
  input  wire logic signed [31:0] in_price,
  input  wire logic signed [31:0] in_quantity,
  input  wire logic [31:0]        in_account,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_status,
  output logic [31:0]             out_maker_id,
  output logic [31:0]             out_taker_id,
  output logic [30:0]             out_fill_price,
  output logic [30:0]             out_exec_qty,
  output logic [30:0]             out_top_bid,
  output logic                    out_bid_valid,
  output logic [30:0]             out_top_ask,
  output logic                    out_ask_valid,
  output logic [30:0]             out_spread_value,
  output logic [5:0]              out_resting_count,
  output logic                    out_last
);

  lob_pkg::cmd_t cmd;
  lob_pkg::sts_t sts;

  lob_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  lob_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_req_type      (in_req_type),
    .in_ord_id        (in_ord_id),
    .in_side          (in_side),
    .in_order_kind    (in_order_kind),
    .in_price         (in_price),
    .in_quantity      (in_quantity),
    .in_account       (in_account),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_maker_id     (out_maker_id),
    .out_taker_id     (out_taker_id),
    .out_fill_price   (out_fill_price),
    .out_exec_qty     (out_exec_qty),
    .out_top_bid      (out_top_bid),
    .out_bid_valid    (out_bid_valid),
    .out_top_ask      (out_top_ask),
    .out_ask_valid    (out_ask_valid),
    .out_spread_value (out_spread_value),
    .out_resting_count(out_resting_count),
    .out_last         (out_last),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

`default_nettype wire

FILE: tb/tb_limit_order_book_matcher.sv
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher
// Self-checking bench for the order book matcher. A directed table covers
// rejects, self-trade skip, sweeps, cancels and field extremes. Random
// traffic follows: well-formed adds and cancels over a small id pool, a burst
// that fills the book, and noise. Every result transaction is checked against
// a behavioral copy of the book kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_limit_order_book_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT     = lob_pkg::ORDER_SLOTS;
  localparam int WDOG_MAX  = 40000;
  localparam int RAND_ITEMS = 276;

  typedef struct {
    logic        req_type;
    logic [31:0] id;
    logic        side;
    logic        kind;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] acct;
    logic        chk;
    lob_pkg::status_t exp_st;
  } order_req_t;

  typedef struct {
    logic [2:0]  st;
    logic [31:0] maker;
    logic [31:0] taker;
    logic [30:0] px;
    logic [30:0] qty;
    logic [30:0] bid;
    logic        bid_v;
    logic [30:0] ask;
    logic        ask_v;
    logic [30:0] spread;
    logic [5:0]  count;
    logic        last;
  } book_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_req_type = 1'b0;
  logic [31:0] in_ord_id = '0;
  logic in_side = 1'b0;
  logic in_order_kind = 1'b0;
  logic signed [31:0] in_price = '0;
  logic signed [31:0] in_quantity = '0;
  logic [31:0] in_account = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [31:0] out_maker_id, out_taker_id;
  logic [30:0] out_fill_price, out_exec_qty, out_top_bid, out_top_ask, out_spread_value;
  logic out_bid_valid, out_ask_valid, out_last;
  logic [5:0] out_resting_count;

  limit_order_book_matcher i_dut (.*);

  always #5 clk = ~clk;

  // book copy
  logic        bk_valid[NSLOT];
  logic [31:0] bk_id[NSLOT];
  logic        bk_side[NSLOT];
  logic [30:0] bk_px[NSLOT];
  logic [30:0] bk_qty[NSLOT];
  logic [31:0] bk_acct[NSLOT];
  logic [31:0] bk_arr[NSLOT];
  logic [31:0] arrival_seq;

  book_result_t exp_results[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic closing = 1'b0;
  logic in_acc_seen, out_acc_seen;

  function automatic void push_status(logic [2:0] st, logic [31:0] id);
    book_result_t r;
    r = '{default: '0};
    r.st = st;
    r.taker = id;
    r.last = 1'b1;
    for (int i = 0; i < NSLOT; i++) begin
      if (bk_valid[i]) begin
        r.count++;
        if (bk_side[i] == lob_pkg::SIDE_BUY) begin
          if (!r.bid_v || bk_px[i] > r.bid) r.bid = bk_px[i];
          r.bid_v = 1'b1;
        end else begin
          if (!r.ask_v || bk_px[i] < r.ask) r.ask = bk_px[i];
          r.ask_v = 1'b1;
        end
      end
    end
    if (r.bid_v && r.ask_v && r.ask > r.bid) r.spread = r.ask - r.bid;
    exp_results.insert(exp_results.size(), r);
  endfunction

  function automatic int find_id(logic [31:0] id);
    for (int i = 0; i < NSLOT; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  // Apply one request to the book copy and queue the results it causes.
  function automatic void match_order(order_req_t r);
    int hit, best, free_slot;
    logic [31:0] rem, age, best_age, fq;
    book_result_t f;
    hit = find_id(r.id);
    if (r.req_type == lob_pkg::REQ_CANCEL) begin
      if (hit >= 0) begin
        bk_valid[hit] = 1'b0;
        push_status(lob_pkg::ST_CANCELLED, r.id);
      end else begin
        push_status(lob_pkg::ST_NOT_FOUND, r.id);
      end
      return;
    end
    if (r.qty == 0 || r.qty[31]) begin
      push_status(lob_pkg::ST_BAD_QTY, r.id);
      return;
    end
    if (r.kind != lob_pkg::KIND_MARKET && (r.price == 0 || r.price[31])) begin
      push_status(lob_pkg::ST_BAD_PRICE, r.id);
      return;
    end
    if (hit >= 0) begin
      push_status(lob_pkg::ST_DUPLICATE, r.id);
      return;
    end
    rem = r.qty;
    while (rem > 0) begin
      best = -1;
      best_age = '0;
      for (int i = 0; i < NSLOT; i++) begin
        if (!bk_valid[i] || bk_side[i] == r.side) continue;
        if (r.acct != 0 && bk_acct[i] == r.acct) continue;
        age = arrival_seq - bk_arr[i];
        if (best < 0) begin
          best = i; best_age = age;
        end else if (bk_px[i] == bk_px[best]) begin
          if (age > best_age) begin best = i; best_age = age; end
        end else if (r.side == lob_pkg::SIDE_BUY ? bk_px[i] < bk_px[best]
                                                 : bk_px[i] > bk_px[best]) begin
          best = i; best_age = age;
        end
      end
      if (best < 0) break;
      // limit price ends the sweep
      if (r.kind != lob_pkg::KIND_MARKET &&
          (r.side == lob_pkg::SIDE_BUY ? {1'b0, bk_px[best]} > r.price
                                       : {1'b0, bk_px[best]} < r.price))
        break;
      fq = (rem < {1'b0, bk_qty[best]}) ? rem : {1'b0, bk_qty[best]};
      f = '{default: '0};
      f.st = lob_pkg::ST_FILL;
      f.maker = bk_id[best];
      f.taker = r.id;
      f.px = bk_px[best];
      f.qty = fq[30:0];
      exp_results.insert(exp_results.size(), f);
      rem -= fq;
      bk_qty[best] -= fq[30:0];
      if (bk_qty[best] == 0) bk_valid[best] = 1'b0;
    end
    if (rem > 0 && r.kind != lob_pkg::KIND_MARKET) begin
      free_slot = -1;
      for (int i = 0; i < NSLOT; i++)
        if (!bk_valid[i]) begin free_slot = i; break; end
      if (free_slot < 0) begin
        push_status(lob_pkg::ST_BOOK_FULL, r.id);
        return;
      end
      bk_valid[free_slot] = 1'b1;
      bk_id[free_slot] = r.id;
      bk_side[free_slot] = r.side;
      bk_px[free_slot] = r.price[30:0];
      bk_qty[free_slot] = rem[30:0];
      bk_acct[free_slot] = r.acct;
      bk_arr[free_slot] = arrival_seq;
      arrival_seq++;
    end
    push_status(lob_pkg::ST_ACCEPTED, r.id);
  endfunction

  task automatic send_req(order_req_t r);
    logic gap;
    in_valid <= 1'b1;
    in_req_type <= r.req_type;
    in_ord_id <= r.id;
    in_side <= r.side;
    in_order_kind <= r.kind;
    in_price <= r.price;
    in_quantity <= r.qty;
    in_account <= r.acct;
    do @(posedge clk); while (in_stall);
    match_order(r);
    if (r.chk && exp_results[$].st != r.exp_st) begin
      $display("%0t: status of request %0h expected %0d actual %0d",
               $time, r.id, r.exp_st, exp_results[$].st);
      errors++;
    end
    gap = ($urandom_range(0, 99) < send_idle_pct);
    if (gap || closing) in_valid <= 1'b0;
    if (gap) repeat ($urandom_range(1, 4)) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_id();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 60);
    if (sel < 85) return $urandom_range(1000, 1040);
    return $urandom;
  endfunction

  function automatic order_req_t rand_req();
    order_req_t r;
    int sel;
    r.chk = 1'b0;
    r.exp_st = lob_pkg::ST_ACCEPTED;
    r.req_type = ($urandom_range(0, 99) < 20);
    r.id = pick_id();
    r.side = 1'($urandom_range(0, 1));
    r.kind = ($urandom_range(0, 99) < 15);
    r.price = $urandom_range(95, 105);
    r.qty = $urandom_range(1, 20);
    r.acct = $urandom_range(0, 3);
    sel = $urandom_range(0, 99);
    if (sel < 8) r.price = $urandom;
    else if (sel < 12) r.qty = $urandom;
    else if (sel < 16) r.acct = $urandom;
    else if (sel < 18) r.price = 0;
    return r;
  endfunction

  // Non-crossing adds that fill the book.
  task automatic fill_burst();
    order_req_t r;
    for (int k = 0; k < 34; k++) begin
      r = '{req_type: 1'b0, id: 1000 + k, side: k[0], kind: 1'b0,
            price: k[0] ? 32'd1000 + k : 32'd1 + k, qty: $urandom_range(1, 50),
            acct: $urandom_range(0, 3), chk: 1'b0, exp_st: lob_pkg::ST_ACCEPTED};
      send_req(r);
    end
  endtask

  // Result checker
  task automatic chk_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    book_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d taker %0h", $time, out_status,
                 out_taker_id);
        errors++;
      end else begin
        e = exp_results.pop_front();
        chk_field("status", 32'(e.st), 32'(out_status));
        chk_field("maker_id", e.maker, out_maker_id);
        chk_field("taker_id", e.taker, out_taker_id);
        chk_field("fill_price", 32'(e.px), 32'(out_fill_price));
        chk_field("exec_qty", 32'(e.qty), 32'(out_exec_qty));
        chk_field("top_bid", 32'(e.bid), 32'(out_top_bid));
        chk_field("bid_valid", 32'(e.bid_v), 32'(out_bid_valid));
        chk_field("top_ask", 32'(e.ask), 32'(out_top_ask));
        chk_field("ask_valid", 32'(e.ask_v), 32'(out_ask_valid));
        chk_field("spread_value", 32'(e.spread), 32'(out_spread_value));
        chk_field("resting_count", 32'(e.count), 32'(out_resting_count));
        chk_field("last", 32'(e.last), 32'(out_last));
      end
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

  // Watchdog: cycles without any transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    in_acc_seen = in_valid && !in_stall;
    out_acc_seen = out_valid && !out_stall;
    if (!rst_n || in_acc_seen || out_acc_seen) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_MAX) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;

  order_req_t directed[20] = '{
    '{1'b1, 5, 0, 0, 100, 1, 0, 1'b1, lob_pkg::ST_NOT_FOUND},
    '{1'b0, 9, 0, 0, 100, 0, 0, 1'b1, lob_pkg::ST_BAD_QTY},
    '{1'b0, 9, 1, 1, 100, 32'h8000_0000, 0, 1'b1, lob_pkg::ST_BAD_QTY},
    '{1'b0, 9, 0, 0, 0, 5, 0, 1'b1, lob_pkg::ST_BAD_PRICE},
    '{1'b0, 9, 1, 0, ALL1, 5, 0, 1'b1, lob_pkg::ST_BAD_PRICE},
    '{1'b0, 9, 0, 1, 32'hFFFF_FFFB, 10, 0, 1'b1, lob_pkg::ST_ACCEPTED},
    '{1'b0, 1, 0, 0, 100, 10, 7, 1'b1, lob_pkg::ST_ACCEPTED},
    '{1'b0, 1, 1, 0, 100, 10, 7, 1'b1, lob_pkg::ST_DUPLICATE},
    '{1'b0, 2, 1, 0, MAXP, MAXP, 0, 1'b1, lob_pkg::ST_ACCEPTED},
    '{1'b0, 3, 0, 0, 100, 5, 8, 1'b0, lob_pkg::ST_ACCEPTED},
    '{1'b0, 4, 1, 0, 90, 12, 7, 1'b0, lob_pkg::ST_ACCEPTED},
    '{1'b0, 5, 1, 1, 50, 30, 0, 1'b0, lob_pkg::ST_ACCEPTED},
    '{1'b0, 6, 0, 1, 0, 3, 9, 1'b0, lob_pkg::ST_ACCEPTED},
    '{1'b1, 2, 0, 0, 0, 0, 0, 1'b1, lob_pkg::ST_CANCELLED},
    '{1'b1, 2, 0, 0, 0, 0, 0, 1'b1, lob_pkg::ST_NOT_FOUND},
    '{1'b0, ALL1, 0, 0, 1, 1, ALL1, 1'b1, lob_pkg::ST_ACCEPTED},
    '{1'b0, 7, 1, 0, 2, 1, 0, 1'b0, lob_pkg::ST_ACCEPTED},
    '{1'b0, 8, 0, 0, 3, 1, 0, 1'b0, lob_pkg::ST_ACCEPTED},
    '{1'b1, ALL1, 1, 1, ALL1, ALL1, ALL1, 1'b1, lob_pkg::ST_CANCELLED},
    '{1'b1, 0, 0, 0, 0, 0, 0, 1'b1, lob_pkg::ST_NOT_FOUND}
  };

  initial begin
    for (int i = 0; i < NSLOT; i++) bk_valid[i] = 1'b0;
    arrival_seq = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 8;
    recv_stall_pct = 48;
    foreach (directed[i]) send_req(directed[i]);
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 8 : (mode == 1) ? 48 : 0;
      recv_stall_pct = (mode == 0) ? 48 : (mode == 1) ? 8 : 0;
      if (mode == 1) fill_burst();
      for (int n = 0; n < RAND_ITEMS / 3; n++) begin
        if (mode == 2 && n == RAND_ITEMS / 3 - 1) closing = 1'b1;
        send_req(rand_req());
      end
    end
    wait (exp_results.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && exp_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/lob_pkg.sv
rtl/lob_ram.sv
rtl/lob_ctrl.sv
rtl/lob_dpath.sv
rtl/limit_order_book_matcher.sv
tb/tb_limit_order_book_matcher.sv
